// File: hw/rtl/cgf_pkg.sv
package cgf_pkg;

    // Line geometry
    localparam int CHIP_WIDTH = 256;
    localparam int CHIP_COUNT = 5;
    localparam int POS_W      = $clog2(CHIP_WIDTH);
    localparam int CHIP_IDX_W = $clog2(CHIP_COUNT);
    localparam logic [POS_W-1:0]      POS_LAST  = POS_W'(CHIP_WIDTH - 1);
    localparam logic [CHIP_IDX_W-1:0] CHIP_LAST = CHIP_IDX_W'(CHIP_COUNT - 1);

    // Field widths
    localparam int PIX_W      = 31;
    localparam int GAP_W      = 5;
    localparam int MODE_W     = 2;
    localparam int K_W        = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Widest gap honoured; the all-ones code falls back to it
    localparam logic [GAP_W-1:0] GAP_MAX = GAP_W'(30);

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_GAP_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE = CFG_IDX_W'(1);
    localparam logic [GAP_W-1:0]     GAP_RESET     = GAP_W'(4);

    // Divider sizing: dividend is a pixel, divisor at most 31
    localparam int DIV_W     = PIX_W;
    localparam int DVS_W     = 5;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int MUL_W     = PIX_W + DVS_W;

    typedef enum logic [MODE_W-1:0] {
        FILL_RAW      = 2'd0,
        FILL_ZERO     = 2'd1,
        FILL_DISPATCH = 2'd2,
        FILL_MEAN     = 2'd3
    } fill_mode_t;

    typedef enum logic [1:0] {
        DIV_OP_LEFT  = 2'd0,
        DIV_OP_RIGHT = 2'd1,
        DIV_OP_STEP  = 2'd2
    } div_op_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DIV_L  = 3'd1,
        S_DIV_R  = 3'd2,
        S_DIV_S  = 3'd3,
        S_PREP   = 3'd4,
        S_RUN    = 3'd5
    } state_t;

    typedef struct packed {
        logic    take;
        logic    pass_load;
        logic    div_start;
        div_op_t div_op;
        logic    acc_load;
        logic    run_emit;
    } cmd_t;

    typedef struct packed {
        logic       out_free;
        logic       at_held;
        logic       at_boundary;
        fill_mode_t mode;
        logic       run_at_last;
        logic       div_busy;
        logic       div_done;
    } status_t;

endpackage

// File: hw/rtl/cgf_if.sv
interface cgf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [cgf_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cgf_res_if;
    logic                      valid;
    logic                      ready;
    logic [cgf_pkg::PIX_W-1:0] pixel_out;
    logic                      run_last;
    logic                      line_end;

    modport source (output valid, output pixel_out, output run_last, output line_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input run_last, input line_end,
                    output ready);
endinterface

interface cgf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cgf_pkg::CFG_IDX_W-1:0]  index;
    logic [cgf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/cgf_div.sv
module cgf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cgf_pkg::DIV_W-1:0]   dividend,
    input  logic [cgf_pkg::DVS_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [cgf_pkg::DIV_W-1:0]   quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [cgf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [cgf_pkg::DIV_W-1:0]       quo_reg, quo_next;
    logic [cgf_pkg::DVS_W-1:0]       rem_reg, rem_next;
    logic [cgf_pkg::DVS_W-1:0]       dvs_reg, dvs_next;
    logic [cgf_pkg::DVS_W:0]         shifted;
    logic [cgf_pkg::DVS_W:0]         trial;
    logic                            fits;

    // One restoring step: bring down the next dividend bit
    always_comb
    begin
        shifted = {rem_reg, quo_reg[cgf_pkg::DIV_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Sequence the quotient bits, most significant first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[cgf_pkg::DIV_W-2:0], fits};
            rem_next = fits ? trial[cgf_pkg::DVS_W-1:0] : shifted[cgf_pkg::DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cgf_pkg::DIV_CNT_W'(cgf_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // A started division reports its quotient after a fixed latency
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |-> ##(cgf_pkg::DIV_W + 1) done_reg)
        else $error("divider did not finish on time");

    // Completion and busy never overlap
    a_div_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider reports done while busy");

endmodule

// File: hw/rtl/cgf_ctrl.sv
module cgf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cgf_pkg::status_t status,
    output cgf_pkg::cmd_t    cmd
);

    cgf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.take      = 1'b0;
        cmd.pass_load = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_op    = cgf_pkg::DIV_OP_LEFT;
        cmd.acc_load  = 1'b0;
        cmd.run_emit  = 1'b0;
        case (state_reg)
            cgf_pkg::S_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.take = 1'b1;
                    if (status.at_boundary)
                    begin
                        if (status.mode == cgf_pkg::FILL_DISPATCH ||
                            status.mode == cgf_pkg::FILL_MEAN)
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_op    = cgf_pkg::DIV_OP_LEFT;
                            state_next    = cgf_pkg::S_DIV_L;
                        end
                        else
                        begin
                            state_next = cgf_pkg::S_RUN;
                        end
                    end
                    else if (!status.at_held)
                    begin
                        cmd.pass_load = 1'b1;
                    end
                end
            end
            cgf_pkg::S_DIV_L:
            begin
                cmd.div_op = cgf_pkg::DIV_OP_RIGHT;
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = cgf_pkg::S_DIV_R;
                end
            end
            cgf_pkg::S_DIV_R:
            begin
                cmd.div_op = cgf_pkg::DIV_OP_STEP;
                if (status.div_done)
                begin
                    if (status.mode == cgf_pkg::FILL_MEAN)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = cgf_pkg::S_DIV_S;
                    end
                    else
                    begin
                        state_next = cgf_pkg::S_RUN;
                    end
                end
            end
            cgf_pkg::S_DIV_S:
            begin
                if (status.div_done)
                begin
                    state_next = cgf_pkg::S_PREP;
                end
            end
            cgf_pkg::S_PREP:
            begin
                cmd.acc_load = 1'b1;
                state_next   = cgf_pkg::S_RUN;
            end
            cgf_pkg::S_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.run_emit = 1'b1;
                    if (status.run_at_last)
                    begin
                        state_next = cgf_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cgf_pkg::S_IDLE;
            end
        endcase
    end

    // Run pixels only go into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_emit |-> status.out_free)
        else $error("run pixel loaded over a pending result");

    // Never restart the divider mid-division
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // The last run pixel returns the controller to idle
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.run_emit && status.run_at_last) |=> (state_reg == cgf_pkg::S_IDLE))
        else $error("run did not end after its last pixel");

endmodule

// File: hw/rtl/cgf_dp.sv
module cgf_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [cgf_pkg::PIX_W-1:0] pixel_in,
    cgf_res_if.source         results,
    cgf_cfg_if.sink           cfg,
    input  cgf_pkg::cmd_t     cmd,
    output cgf_pkg::status_t  status
);

    // Configuration
    logic [cgf_pkg::GAP_W-1:0]      gap_width_reg;
    cgf_pkg::fill_mode_t            fill_mode_reg;

    // Line position
    logic [cgf_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [cgf_pkg::CHIP_IDX_W-1:0] chip_reg, chip_next;

    // Boundary run operands
    logic [cgf_pkg::PIX_W-1:0]      held_left_reg;
    logic [cgf_pkg::PIX_W-1:0]      right_reg;
    logic [cgf_pkg::PIX_W-1:0]      share_l_reg;
    logic [cgf_pkg::PIX_W-1:0]      share_r_reg;
    logic [cgf_pkg::PIX_W-1:0]      step_reg;
    logic [cgf_pkg::PIX_W-1:0]      acc_reg;
    logic                           neg_reg;
    cgf_pkg::div_op_t               dest_reg;
    logic [cgf_pkg::K_W-1:0]        k_reg;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [cgf_pkg::PIX_W-1:0]      out_pixel_reg;
    logic                           out_last_reg;
    logic                           out_end_reg;

    logic [cgf_pkg::GAP_W-1:0]      gap;
    logic [cgf_pkg::DVS_W-1:0]      share_n;
    logic [cgf_pkg::DVS_W-1:0]      gap_plus1;
    logic [cgf_pkg::K_W:0]          right_first;
    logic                           at_line_end;
    logic                           out_free;
    logic [cgf_pkg::PIX_W:0]        diff;
    logic [cgf_pkg::PIX_W-1:0]      diff_mag;
    logic [cgf_pkg::DIV_W-1:0]      div_dividend;
    logic [cgf_pkg::DVS_W-1:0]      div_divisor;
    logic                           div_busy;
    logic                           div_done;
    logic [cgf_pkg::DIV_W-1:0]      div_quotient;
    logic [cgf_pkg::MUL_W-1:0]      ramp_prod;
    logic [cgf_pkg::PIX_W-1:0]      run_value;

    // Run geometry from the clamped gap
    always_comb
    begin
        gap         = (gap_width_reg > cgf_pkg::GAP_MAX) ? cgf_pkg::GAP_MAX : gap_width_reg;
        share_n     = cgf_pkg::DVS_W'(gap[cgf_pkg::GAP_W-1:1]) + 1'b1;
        gap_plus1   = cgf_pkg::DVS_W'(gap) + 1'b1;
        right_first = (cgf_pkg::K_W+1)'(gap) + (cgf_pkg::K_W+1)'(2)
                    - (cgf_pkg::K_W+1)'(share_n);
        at_line_end = (pos_reg == cgf_pkg::POS_LAST) && (chip_reg == cgf_pkg::CHIP_LAST);
        out_free    = !out_valid_reg || results.ready;
    end

    // Configuration writes; always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_width_reg <= cgf_pkg::GAP_RESET;
            fill_mode_reg <= cgf_pkg::FILL_RAW;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == cgf_pkg::REG_GAP_WIDTH)
            begin
                gap_width_reg <= cfg.data[cgf_pkg::GAP_W-1:0];
            end
            else if (cfg.index == cgf_pkg::REG_FILL_MODE)
            begin
                fill_mode_reg <= cgf_pkg::fill_mode_t'(cfg.data[cgf_pkg::MODE_W-1:0]);
            end
        end
    end

    // Advance the column, wrapping at the end of the line
    always_comb
    begin
        pos_next  = pos_reg;
        chip_next = chip_reg;
        if (cmd.take)
        begin
            if (pos_reg == cgf_pkg::POS_LAST)
            begin
                pos_next  = '0;
                chip_next = (chip_reg == cgf_pkg::CHIP_LAST) ? '0 : chip_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            chip_reg      <= '0;
            held_left_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            chip_reg <= chip_next;
            if (cmd.take && status.at_held)
            begin
                held_left_reg <= pixel_in;
            end
        end
    end

    // Divider operand selection; the step division starts on the very cycle the
    // right share completes, so take that share straight from the divider
    always_comb
    begin
        diff     = {1'b0, share_l_reg} - {1'b0, div_quotient};
        diff_mag = diff[cgf_pkg::PIX_W] ? (~diff[cgf_pkg::PIX_W-1:0] + 1'b1)
                                        : diff[cgf_pkg::PIX_W-1:0];
        case (cmd.div_op)
            cgf_pkg::DIV_OP_LEFT:
            begin
                div_dividend = held_left_reg;
                div_divisor  = share_n;
            end
            cgf_pkg::DIV_OP_RIGHT:
            begin
                div_dividend = right_reg;
                div_divisor  = share_n;
            end
            cgf_pkg::DIV_OP_STEP:
            begin
                div_dividend = diff_mag;
                div_divisor  = gap_plus1;
            end
            default:
            begin
                div_dividend = held_left_reg;
                div_divisor  = share_n;
            end
        endcase
    end

    cgf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Ramp start: F + (g+1)*step, modulo the pixel width
    assign ramp_prod = cgf_pkg::MUL_W'(gap_plus1) * cgf_pkg::MUL_W'(step_reg);

    // Capture operands and quotients, walk the run
    always_ff @(posedge clk)
    begin
        if (cmd.take && status.at_boundary)
        begin
            right_reg <= pixel_in;
        end
        if (cmd.div_start)
        begin
            dest_reg <= cmd.div_op;
            neg_reg  <= diff[cgf_pkg::PIX_W];
        end
        if (div_done)
        begin
            case (dest_reg)
                cgf_pkg::DIV_OP_LEFT:  share_l_reg <= div_quotient;
                cgf_pkg::DIV_OP_RIGHT: share_r_reg <= div_quotient;
                cgf_pkg::DIV_OP_STEP:  step_reg    <= neg_reg ? (~div_quotient + 1'b1)
                                                              : div_quotient;
                default:               share_l_reg <= div_quotient;
            endcase
        end
        if (cmd.acc_load)
        begin
            acc_reg <= share_r_reg + ramp_prod[cgf_pkg::PIX_W-1:0];
        end
        else if (cmd.run_emit)
        begin
            acc_reg <= acc_reg - step_reg;
        end
        if (cmd.take)
        begin
            k_reg <= '0;
        end
        else if (cmd.run_emit)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // Value of the current run position
    always_comb
    begin
        case (fill_mode_reg)
            cgf_pkg::FILL_RAW:
            begin
                if (k_reg == '0)
                begin
                    run_value = held_left_reg;
                end
                else if (k_reg == gap_plus1)
                begin
                    run_value = right_reg;
                end
                else
                begin
                    run_value = '0;
                end
            end
            cgf_pkg::FILL_ZERO:
            begin
                run_value = '0;
            end
            cgf_pkg::FILL_DISPATCH:
            begin
                run_value = ((cgf_pkg::K_W+1)'(k_reg) >= right_first) ? share_r_reg
                                                                        : share_l_reg;
            end
            cgf_pkg::FILL_MEAN:
            begin
                run_value = acc_reg;
            end
            default:
            begin
                run_value = '0;
            end
        endcase
    end

    // Output register: load on pass-through or run, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.pass_load || cmd.run_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_load)
        begin
            out_pixel_reg <= pixel_in;
            out_last_reg  <= 1'b1;
            out_end_reg   <= at_line_end;
        end
        else if (cmd.run_emit)
        begin
            out_pixel_reg <= run_value;
            out_last_reg  <= status.run_at_last;
            out_end_reg   <= 1'b0;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.pixel_out = out_pixel_reg;
    assign results.run_last  = out_last_reg;
    assign results.line_end  = out_end_reg;

    // Status towards the controller
    always_comb
    begin
        status.out_free    = out_free;
        status.at_held     = (pos_reg == cgf_pkg::POS_LAST) && (chip_reg != cgf_pkg::CHIP_LAST);
        status.at_boundary = (pos_reg == '0) && (chip_reg != '0);
        status.mode        = fill_mode_reg;
        status.run_at_last = (k_reg == gap_plus1);
        status.div_busy    = div_busy;
        status.div_done    = div_done;
    end

endmodule

// File: hw/rtl/chip_row_gap_filler.sv
// Chip row gap filler. Pixels of a detector line (CHIP_COUNT chips of CHIP_WIDTH
// pixels) enter on the pixels channel, one per transaction, and leave on the
// results channel with gap_width pixels inserted between neighbouring chips.
// Ordinary pixels pass at one per cycle, while the results channel is ready,
// through a single output register. The last pixel of each chip but the last
// is held and gives no result; the first pixel of the next chip then produces
// a run of gap_width+2 results, emitted at one per cycle while the results
// channel is ready, during which no pixel is accepted. Raw and zero fill start
// the run at once. Dispatch fill first computes two shares, one after the
// other, on the shared bit-serial divider before the run; linear mean needs a
// third quotient and a ramp set-up state. run_last marks the final result of
// each input, line_end the final pixel of an output line. Write gap_width
// (index 0) and fill_mode (index 1) only while no run is pending.
module chip_row_gap_filler (
    input  logic      clk,
    input  logic      rst_n,
    cgf_pix_if.sink   pixels,
    cgf_res_if.source results,
    cgf_cfg_if.sink   cfg
);

    cgf_pkg::cmd_t    cmd;
    cgf_pkg::status_t status;

    cgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cgf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixels.pixel_in),
        .results  (results),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
